>>> hdl/qsd_pkg.sv
// Shared types, constants and dequantization tables for the QOA slice decoder.
package qsd_pkg;

  localparam int CHANNELS    = 2;
  localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAPS        = 4;
  localparam int MAX_SAMPLES = 20;
  localparam int CNT_W       = 5;
  localparam int CODE_BITS   = 60;
  localparam int PRED_SHIFT  = 13;
  localparam int DELTA_SHIFT = 4;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef logic signed [15:0] word_t;
  // element 0 sits in the top 16 bits of a packed 64-bit word
  typedef word_t [0:TAPS-1] taps_t;

  typedef struct packed {
    taps_t hist;
    taps_t wts;
  } lms_row_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_ACC
  } qsd_state_t;

  // round((k+1)^2.75)
  function automatic logic [11:0] scale_lut(input logic [3:0] sfq);
    logic [11:0] sf;
    unique case (sfq)
      4'd0:  sf = 12'd1;
      4'd1:  sf = 12'd7;
      4'd2:  sf = 12'd21;
      4'd3:  sf = 12'd45;
      4'd4:  sf = 12'd84;
      4'd5:  sf = 12'd138;
      4'd6:  sf = 12'd211;
      4'd7:  sf = 12'd304;
      4'd8:  sf = 12'd421;
      4'd9:  sf = 12'd562;
      4'd10: sf = 12'd731;
      4'd11: sf = 12'd928;
      4'd12: sf = 12'd1157;
      4'd13: sf = 12'd1419;
      4'd14: sf = 12'd1715;
      default: sf = 12'd2048;
    endcase
    return sf;
  endfunction

  // dequant levels in quarter units
  function automatic logic signed [5:0] dq4_lut(input logic [2:0] code);
    logic signed [5:0] q;
    unique case (code)
      3'd0: q = 6'sd3;
      3'd1: q = -6'sd3;
      3'd2: q = 6'sd10;
      3'd3: q = -6'sd10;
      3'd4: q = 6'sd18;
      3'd5: q = -6'sd18;
      3'd6: q = 6'sd28;
      default: q = -6'sd28;
    endcase
    return q;
  endfunction

  // sf * q4 / 4, rounded half away from zero
  function automatic word_t dequant(input logic [3:0] sfq, input logic [2:0] code);
    logic signed [17:0] sfs;
    logic signed [17:0] qs;
    logic signed [17:0] x;
    logic signed [17:0] r;
    sfs = signed'(18'(scale_lut(sfq)));
    qs  = 18'(dq4_lut(code));
    x   = sfs * qs;
    if (!x[17]) begin
      r = (x + 18'sd2) >>> 2;
    end else begin
      r = -((-x + 18'sd2) >>> 2);
    end
    return word_t'(r[15:0]);
  endfunction

endpackage

>>> hdl/qsd_channels.sv
// Valid/ready channel interfaces for slice items and decoded samples.
interface qsd_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        channel;
  logic [63:0] slice_word;
  logic [63:0] weights_word;
  logic [4:0]  sample_count;

  modport source(output valid, op, channel, slice_word, weights_word, sample_count,
                 input ready);
  modport sink(input valid, op, channel, slice_word, weights_word, sample_count,
               output ready);
endinterface

interface qsd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               out_channel;
  logic               last;

  modport source(output valid, sample, out_channel, last, input ready);
  modport sink(input valid, sample, out_channel, last, output ready);
endinterface

>>> hdl/qsd_predict.sv
// LMS predictor: registered tap products, then sum, shift, residual add and saturation.
module qsd_predict (
  input  logic          clk,
  input  logic          mul_en,
  input  qsd_pkg::taps_t hist,
  input  qsd_pkg::taps_t wts,
  input  qsd_pkg::word_t residual,
  output qsd_pkg::word_t sample
);
  import qsd_pkg::*;

  logic signed [31:0] prod [TAPS];
  logic signed [33:0] acc;
  logic signed [20:0] pred;
  logic signed [21:0] total;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      for (int n = 0; n < TAPS; n++) begin
        prod[n] <= hist[n] * wts[n];
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int n = 0; n < TAPS; n++) begin
      acc = acc + 34'(prod[n]);
    end
    // floor shift
    pred  = acc[33:PRED_SHIFT];
    total = 22'(pred) + 22'(residual);
    if (total < -22'sd32768) begin
      sample = 16'sh8000;
    end else if (total > 22'sd32767) begin
      sample = 16'sh7fff;
    end else begin
      sample = total[15:0];
    end
  end

endmodule

>>> hdl/qoa_slice_lms_decoder.sv
// Top level: QOA slice decoder with per-channel LMS state held in a row memory.
//
//  port     dir   payload                                       transfer when
//  items    sink  op, channel, slice_word, weights_word, count  valid && ready
//  samples  src   sample, out_channel, last                     valid && ready
//
// A load item writes the channel's row directly in the same cycle as its transfer.
// A decode of n samples (count clamped to 20) holds ready low after its transfer
// through a memory read state, then per sample a multiply state and a sum/saturate
// state, since each sample feeds the next prediction.
// Reset clears the row valid bits, so an unwritten row reads as all zeros.
// A full output register stalls the sum/saturate step; items wait for the row write-back.
module qoa_slice_lms_decoder (
  input logic         clk,
  input logic         rst,
  qsd_item_if.sink    items,
  qsd_sample_if.source samples
);
  import qsd_pkg::*;

  qsd_state_t state, state_next;

  // row memory, one row per channel
  lms_row_t             mem [CHANNELS];
  lms_row_t             rd_row;
  logic                 rd_valid;
  logic [CHANNELS-1:0]  row_valid;
  logic                 mem_we;
  logic [CH_AW-1:0]     mem_addr;
  lms_row_t             mem_wdata;

  // handshake and control
  logic                 items_ready;
  logic                 accept;
  logic                 ch_ok;
  logic [CH_AW-1:0]     in_idx;
  logic [CNT_W-1:0]     cnt_clamp;
  logic                 mul_en;
  logic                 out_load;

  // working state of the slice in flight
  logic [CH_AW-1:0]     ch_q;
  logic [3:0]           sfq;
  logic [CODE_BITS-1:0] codes;
  logic [CNT_W-1:0]     remaining;
  taps_t                hist, wts;
  taps_t                hist_next, wts_next;
  word_t                resid;
  word_t                delta;
  word_t                pred_sample;

  // output register
  logic                 out_valid;
  word_t                out_sample;
  logic                 out_ch;
  logic                 out_last;

  assign in_idx    = CH_AW'(items.channel);
  assign ch_ok     = (32'(items.channel) < CHANNELS);
  assign cnt_clamp = (items.sample_count > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                                : items.sample_count;
  assign accept    = items.valid && items_ready;
  assign items.ready = items_ready;

  assign samples.valid       = out_valid;
  assign samples.sample      = out_sample;
  assign samples.out_channel = out_ch;
  assign samples.last        = out_last;

  qsd_predict u_predict (
    .clk      (clk),
    .mul_en   (mul_en),
    .hist     (hist),
    .wts      (wts),
    .residual (resid),
    .sample   (pred_sample)
  );

  // weight step uses history before the shift
  assign delta = resid >>> DELTA_SHIFT;
  always_comb begin
    for (int n = 0; n < TAPS; n++) begin
      wts_next[n] = hist[n][15] ? (wts[n] - delta) : (wts[n] + delta);
    end
    for (int n = 0; n < TAPS - 1; n++) begin
      hist_next[n] = hist[n+1];
    end
    hist_next[TAPS-1] = pred_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    items_ready = 1'b0;
    mul_en      = 1'b0;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = ch_q;
    mem_wdata   = '{hist: hist_next, wts: wts_next};
    unique case (state)
      ST_IDLE: begin
        items_ready = 1'b1;
        if (items.valid && ch_ok) begin
          if (items.op == OP_LOAD) begin
            mem_we    = 1'b1;
            mem_addr  = in_idx;
            mem_wdata = '{hist: taps_t'(items.slice_word),
                          wts:  taps_t'(items.weights_word)};
          end else if (cnt_clamp != '0) begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: state_next = ST_MUL;
      ST_MUL: begin
        mul_en     = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (!out_valid || samples.ready) begin
          out_load = 1'b1;
          if (remaining == CNT_W'(1)) begin
            mem_we     = 1'b1;      // write the row back with the final sample
            state_next = ST_IDLE;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (accept) begin
      rd_row <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (mem_we) begin
        row_valid[mem_addr] <= 1'b1;
      end
      if (accept) begin
        rd_valid <= row_valid[in_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (accept) begin
      remaining <= cnt_clamp;
    end else if (out_load) begin
      remaining <= remaining - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q  <= in_idx;
      sfq   <= items.slice_word[63:60];
      codes <= items.slice_word[CODE_BITS-1:0];
    end else if (out_load) begin
      codes <= {codes[CODE_BITS-4:0], 3'b000};
    end
    if (state == ST_FETCH) begin
      hist <= rd_valid ? rd_row.hist : '0;
      wts  <= rd_valid ? rd_row.wts  : '0;
    end else if (out_load) begin
      hist <= hist_next;
      wts  <= wts_next;
    end
    if (mul_en) begin
      resid <= dequant(sfq, codes[CODE_BITS-1:CODE_BITS-3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (samples.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= pred_sample;
      out_ch     <= ch_q[0];
      out_last   <= (remaining == CNT_W'(1));
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || samples.ready))
    else $error("output register overwritten before transfer");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL || state == ST_ACC) |-> (remaining != '0))
    else $error("slice in flight with no samples left");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && remaining == CNT_W'(1)) |=> (state == ST_IDLE && out_last))
    else $error("final sample did not end the slice");

  a_acc_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC) |-> ($past(state) == ST_MUL || $past(state) == ST_ACC))
    else $error("sum step entered without fresh products");
`endif

endmodule

>>> tb/sv/qoa_slice_lms_decoder_tb.sv
// Self-checking testbench for the QOA slice decoder: LMS predictor, random traffic, stalls.
module qoa_slice_lms_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qsd_pkg::*;

  // ---------------------------------------------------------------------------
  // Run constants
  // ---------------------------------------------------------------------------
  localparam int RANDOM_ITEMS = 158;
  // Receiver hold-off: long enough that the output register fills, the
  // decoder stalls mid-slice and the item channel backs up.
  localparam int HOLD_CYCLES  = 200;
  // Drain after the last expected sample.
  localparam int DRAIN_CYCLES = 60;
  // Cycles with no transfer on either channel before the run is called hung.
  // Worst correct gap is the hold-off plus one slice plus a random stall.
  localparam int STALL_LIMIT  = 3000;

  typedef struct {
    logic        op;
    logic        channel;
    logic [63:0] slice_word;
    logic [63:0] weights_word;
    logic [4:0]  sample_count;
  } slice_item_t;

  typedef struct {
    word_t sample;
    logic  channel;
    logic  last;
  } sample_due_t;

  logic clk = 1'b0;
  logic rst;

  qsd_item_if   items_bus ();
  qsd_sample_if samples_bus ();

  qoa_slice_lms_decoder uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_bus),
    .samples (samples_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: per-channel history and weights, zero after reset
  // ---------------------------------------------------------------------------
  word_t chan_hist [CHANNELS][TAPS];
  word_t chan_wts  [CHANNELS][TAPS];

  // round((k+1)^2.75) and dequant levels in quarter units
  int scale_tab   [16] = '{1, 7, 21, 45, 84, 138, 211, 304,
                           421, 562, 731, 928, 1157, 1419, 1715, 2048};
  int quarter_lvl [8]  = '{3, -3, 10, -10, 18, -18, 28, -28};

  slice_item_t slice_queue [$];   // items waiting to be driven
  sample_due_t samples_due [$];   // predicted samples, oldest first
  slice_item_t on_bus;            // item currently offered

  int total_items;
  int items_taken;
  int mismatches;
  int hold_left;
  bit hold_done;
  int quiet_cycles;

  // Applies one accepted item to the predictor state and queues its samples.
  task automatic predict_samples(input slice_item_t it);
    int unsigned ch;
    int unsigned cnt;
    int          r;
    int          delta;
    int          s;
    longint      acc;
    logic [3:0]  sfq;
    logic [2:0]  code;
    sample_due_t rec;
    ch = it.channel;
    if (ch >= CHANNELS) return;
    if (it.op == OP_LOAD) begin
      for (int n = 0; n < TAPS; n++) begin
        chan_hist[ch][n] = it.slice_word[63-16*n -: 16];
        chan_wts[ch][n]  = it.weights_word[63-16*n -: 16];
      end
      return;
    end
    cnt = (it.sample_count > MAX_SAMPLES) ? MAX_SAMPLES : it.sample_count;
    sfq = it.slice_word[63:60];
    for (int unsigned j = 0; j < cnt; j++) begin
      code = it.slice_word[59-3*j -: 3];
      r = scale_tab[sfq] * quarter_lvl[code];
      // quarter units back to samples, half away from zero
      r = (r >= 0) ? (r + 2) / 4 : -((-r + 2) / 4);
      acc = 0;
      for (int n = 0; n < TAPS; n++)
        acc += longint'(chan_hist[ch][n]) * longint'(chan_wts[ch][n]);
      s = int'(acc >>> PRED_SHIFT) + r;
      if (s < -32768) s = -32768;
      if (s > 32767) s = 32767;
      rec.sample  = word_t'(s);
      rec.channel = it.channel;
      rec.last    = (j + 1 == cnt);
      samples_due = {samples_due, rec};
      // sign-of-history weight update, wraps at 16 bits
      delta = r >>> DELTA_SHIFT;
      for (int n = 0; n < TAPS; n++)
        chan_wts[ch][n] = word_t'(int'(chan_wts[ch][n]) +
                                  ((chan_hist[ch][n] < 0) ? -delta : delta));
      for (int n = 0; n < TAPS - 1; n++)
        chan_hist[ch][n] = chan_hist[ch][n+1];
      chan_hist[ch][TAPS-1] = word_t'(s);
    end
  endtask

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic add_item(input logic op, input logic ch, input logic [63:0] sw,
                          input logic [63:0] ww, input logic [4:0] cnt);
    slice_item_t it;
    it.op           = op;
    it.channel      = ch;
    it.slice_word   = sw;
    it.weights_word = ww;
    it.sample_count = cnt;
    slice_queue = {slice_queue, it};
  endtask

  // Slice with scale index sfq; code j is (first + step*j) mod 8.
  function automatic logic [63:0] slice_of(input logic [3:0] sfq, input int first,
                                           input int step);
    logic [63:0] w;
    w = '0;
    w[63:60] = sfq;
    for (int j = 0; j < MAX_SAMPLES; j++)
      w[59-3*j -: 3] = 3'((first + step * j) % 8);
    return w;
  endfunction

  function automatic word_t rand_span(input int span);
    return word_t'(int'($urandom_range(2 * span)) - span);
  endfunction

  // Idle percentage by traffic phase: sender 27 / receiver 55 first,
  // then swapped, then no idling at all.
  function automatic int idle_pct(input bit rx);
    if (items_taken < total_items / 3) return rx ? 55 : 27;
    if (items_taken < (2 * total_items) / 3) return rx ? 27 : 55;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] hw;
    logic [63:0] ww;
    int          pick;
    logic [4:0]  cnt;
    foreach (chan_hist[c, n]) begin
      chan_hist[c][n] = '0;
      chan_wts[c][n]  = '0;
    end
    items_taken  = 0;
    mismatches   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    quiet_cycles = 0;
    rst = 1'b1;
    items_bus.valid        = 1'b0;
    items_bus.op           = OP_LOAD;
    items_bus.channel      = 1'b0;
    items_bus.slice_word   = '0;
    items_bus.weights_word = '0;
    items_bus.sample_count = '0;
    samples_bus.ready      = 1'b0;

    // Directed part.
    // Decode straight after reset: zero state, residual only.
    add_item(OP_DECODE, 1'b0, slice_of(4'd15, 0, 1), '0, 5'd20);
    // Largest positive prediction: saturates high, weights wrap.
    add_item(OP_LOAD, 1'b0, {4{16'h7FFF}}, {4{16'h7FFF}}, 5'd20);
    add_item(OP_DECODE, 1'b0, slice_of(4'd15, 6, 0), '0, 5'd20);
    // Largest negative prediction on the other channel: saturates low.
    add_item(OP_LOAD, 1'b1, {4{16'h8000}}, {4{16'h7FFF}}, 5'd0);
    add_item(OP_DECODE, 1'b1, slice_of(4'd15, 7, 0), '1, 5'd20);
    // Most negative history times most negative weights: largest product sum.
    add_item(OP_LOAD, 1'b0, {4{16'h8000}}, {4{16'h8000}}, 5'd31);
    add_item(OP_DECODE, 1'b0, slice_of(4'd0, 0, 0), '0, 5'd1);
    // Count of zero leaves the state alone.
    add_item(OP_DECODE, 1'b0, slice_of(4'd9, 3, 1), '0, 5'd0);
    // Counts above twenty clamp.
    add_item(OP_DECODE, 1'b1, slice_of(4'd4, 2, 3), '0, 5'd31);
    add_item(OP_DECODE, 1'b0, slice_of(4'd12, 5, 1), '0, 5'd21);
    // Typical stream start: zero history, standard initial weights.
    add_item(OP_LOAD, 1'b0, '0, {16'h0000, 16'h0000, 16'hE000, 16'h4000}, 5'd0);
    add_item(OP_DECODE, 1'b0, slice_of(4'd0, 0, 1), '0, 5'd20);
    // Partial slice: codes past the count are all but one nonzero and must be ignored.
    add_item(OP_DECODE, 1'b0, slice_of(4'd6, 1, 5) | 64'hF, '1, 5'd7);
    add_item(OP_LOAD, 1'b1, '0, '0, 5'd0);
    add_item(OP_DECODE, 1'b1, slice_of(4'd8, 4, 7), '0, 5'd13);
    // All-ones load and slice, and an all-zero slice.
    add_item(OP_LOAD, 1'b1, '1, '1, 5'd31);
    add_item(OP_DECODE, 1'b1, '1, '1, 5'd31);
    add_item(OP_DECODE, 1'b0, '0, '0, 5'd20);
    // Scale indexes spread over the range, both channels interleaved.
    for (int k = 0; k < 4; k++)
      add_item(OP_DECODE, k[0], slice_of(4'(k * 5), k, k + 1), '0, 5'd20);

    // Random part: mostly decodes on a plausible LMS state, some raw loads.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        hw = {rand_span(2048), rand_span(2048), rand_span(2048), rand_span(2048)};
        ww = {rand_span(16384), rand_span(16384), rand_span(16384), rand_span(16384)};
        add_item(OP_LOAD, 1'($urandom_range(1)), hw, ww, 5'($urandom_range(31)));
      end else if (pick < 20) begin
        add_item(OP_LOAD, 1'($urandom_range(1)), {$urandom, $urandom},
                 {$urandom, $urandom}, 5'($urandom_range(31)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 70)      cnt = 5'd20;
        else if (pick < 88) cnt = 5'($urandom_range(19, 1));
        else if (pick < 94) cnt = 5'd0;
        else                cnt = 5'($urandom_range(31, 21));
        add_item(OP_DECODE, 1'($urandom_range(1)), {$urandom, $urandom},
                 {$urandom, $urandom}, cnt);
      end
    end
    total_items = slice_queue.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (items_taken != total_items) @(posedge clk);
    while (samples_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Item driver: predicts on each transfer, then offers the next queued item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      items_bus.valid <= 1'b0;
    end else begin
      if (items_bus.valid && items_bus.ready) begin
        predict_samples(on_bus);
        items_taken++;
      end
      // payload may only change once the current offer is taken or withdrawn
      if (!items_bus.valid || items_bus.ready) begin
        if (slice_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          on_bus = slice_queue.pop_front();
          items_bus.valid        <= 1'b1;
          items_bus.op           <= on_bus.op;
          items_bus.channel      <= on_bus.channel;
          items_bus.slice_word   <= on_bus.slice_word;
          items_bus.weights_word <= on_bus.weights_word;
          items_bus.sample_count <= on_bus.sample_count;
        end else begin
          items_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample monitor and receiver backpressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sample_due_t exp_s;
    if (rst) begin
      samples_bus.ready <= 1'b0;
    end else begin
      if (samples_bus.valid && samples_bus.ready) begin
        if (samples_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected sample %0d ch %0b last %0b",
                                  samples_bus.sample, samples_bus.out_channel,
                                  samples_bus.last));
        end else begin
          exp_s = samples_due.pop_front();
          if (samples_bus.sample !== exp_s.sample)
            flag_mismatch($sformatf("sample got %0d want %0d",
                                    samples_bus.sample, exp_s.sample));
          if (samples_bus.out_channel !== exp_s.channel)
            flag_mismatch($sformatf("out_channel got %0b want %0b",
                                    samples_bus.out_channel, exp_s.channel));
          if (samples_bus.last !== exp_s.last)
            flag_mismatch($sformatf("last got %0b want %0b",
                                    samples_bus.last, exp_s.last));
        end
      end
      // one long hold-off in the no-idle phase so the sender keeps pushing
      if (hold_left != 0) begin
        hold_left--;
        samples_bus.ready <= 1'b0;
      end else if (!hold_done && items_taken >= (3 * total_items) / 4) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        samples_bus.ready <= 1'b0;
      end else begin
        samples_bus.ready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no transfer on either side for too long means a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if ((items_bus.valid && items_bus.ready) || (samples_bus.valid && samples_bus.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
